>>> design/tlac_pkg.sv
// Shared constants, types and controller states for the transpose list cost block.
`timescale 1ns / 1ps

package tlac_pkg;

    localparam int ENTRIES   = 1024;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int FIELD_W   = 10;
    localparam int PAGE_W    = 11;
    localparam int COST_W    = 11;
    localparam int TOTAL_W   = 48;
    localparam int DIV_CNT_W = $clog2(IDX_W + 1);
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam int COST_MAX = 2 ** COST_W - 1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // word index of each configuration register (paddr[2])
    localparam logic REG_ENTRIES_PER_PAGE = 1'b0;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_ACCESS = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_POS_RD,
        ST_POS_CAP,
        ST_RD_HERE,
        ST_RD_PREV,
        ST_WR_A,
        ST_WR_B,
        ST_PP_WR,
        ST_PI_RD,
        ST_PI_WR,
        ST_WAIT
    } tlac_state_t;

    typedef struct packed {
        logic latch;
        logic load_wr;
        logic pos_cap;
        logic ord_rd_prev;
        logic ord_wr_a;
        logic ord_wr_b;
        logic pp_wr;
        logic pi_wr;
        logic finish;
    } tlac_cmd_t;

    typedef struct packed {
        logic pos_zero;
        logic div_done;
    } tlac_stat_t;

endpackage

>>> design/tlac_div.sv
// Restoring divider: list position by page size, one quotient bit per cycle.
`timescale 1ns / 1ps

module tlac_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [tlac_pkg::IDX_W-1:0]   dividend,
    input  logic [tlac_pkg::PAGE_W-1:0]  divisor,
    output logic [tlac_pkg::IDX_W-1:0]   quotient,
    output logic                         done
);
    import tlac_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [PAGE_W-1:0]    rem_reg, rem_next;
    logic [IDX_W-1:0]     quo_reg, quo_next;
    logic [PAGE_W-1:0]    dsr_reg, dsr_next;
    logic [PAGE_W:0]      trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quo_reg[IDX_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(IDX_W);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit and subtract where it fits
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = PAGE_W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[IDX_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[PAGE_W-1:0];
                quo_next = {quo_reg[IDX_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign done     = !busy_reg;

endmodule

>>> design/tlac_dpath.sv
// Datapath: order and position tables, page divider, cost and running total.
`timescale 1ns / 1ps

module tlac_dpath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tlac_pkg::tlac_cmd_t           cmd,
    output tlac_pkg::tlac_stat_t          stat,
    input  logic                          kind,
    input  logic [tlac_pkg::FIELD_W-1:0]  slot,
    input  logic [tlac_pkg::FIELD_W-1:0]  item_id,
    input  logic [tlac_pkg::PAGE_W-1:0]   page,
    output logic                          done,
    output logic [tlac_pkg::COST_W-1:0]   access_cost,
    output logic [tlac_pkg::TOTAL_W-1:0]  total_cost
);
    import tlac_pkg::*;

    logic [IDX_W-1:0] order_mem [ENTRIES];
    logic [IDX_W-1:0] position_mem [ENTRIES];

    logic             kind_reg;
    logic [IDX_W-1:0] slot_reg, id_reg, pos_reg, here_reg, prev_reg;
    logic [IDX_W-1:0] ord_rdata_reg, pos_rdata_reg;
    logic [IDX_W-1:0] pos_m1;

    logic             ord_we, pos_we;
    logic [IDX_W-1:0] ord_waddr, ord_wdata, ord_raddr;
    logic [IDX_W-1:0] pos_waddr, pos_wdata, pos_raddr;

    logic [PAGE_W-1:0] page_eff;
    logic [IDX_W-1:0]  quotient;
    logic [IDX_W:0]    cost_full;
    logic              div_done;

    logic                done_reg;
    logic [COST_W-1:0]   cost_reg, cost_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;

    assign pos_m1   = pos_reg - 1'b1;
    assign page_eff = (page == '0) ? PAGE_W'(1) : page;

    always_comb
    begin
        ord_we    = 1'b0;
        ord_waddr = slot_reg;
        ord_wdata = id_reg;
        if (cmd.load_wr)
        begin
            ord_we = 1'b1;
        end
        else if (cmd.ord_wr_a)
        begin
            ord_we    = 1'b1;
            ord_waddr = pos_m1;
            ord_wdata = here_reg;
        end
        else if (cmd.ord_wr_b)
        begin
            ord_we    = 1'b1;
            ord_waddr = pos_reg;
            ord_wdata = prev_reg;
        end
        ord_raddr = cmd.ord_rd_prev ? pos_m1 : pos_reg;
    end

    always_comb
    begin
        pos_we    = 1'b0;
        pos_waddr = id_reg;
        pos_wdata = slot_reg;
        if (cmd.load_wr)
        begin
            pos_we = 1'b1;
        end
        else if (cmd.pp_wr)
        begin
            pos_we    = 1'b1;
            pos_waddr = prev_reg;
            pos_wdata = pos_rdata_reg + 1'b1;
        end
        else if (cmd.pi_wr)
        begin
            pos_we    = 1'b1;
            pos_wdata = pos_rdata_reg - 1'b1;
        end
        // predecessor's entry is fetched while its order slot is written back
        pos_raddr = cmd.ord_wr_b ? prev_reg : id_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
        begin
            order_mem[ord_waddr] <= ord_wdata;
        end
        ord_rdata_reg <= order_mem[ord_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            position_mem[pos_waddr] <= pos_wdata;
        end
        pos_rdata_reg <= position_mem[pos_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg <= kind;
            slot_reg <= IDX_W'(slot);
            id_reg   <= IDX_W'(item_id);
        end
        if (cmd.pos_cap)
        begin
            pos_reg <= pos_rdata_reg;
        end
        if (cmd.ord_rd_prev)
        begin
            here_reg <= ord_rdata_reg;
        end
        if (cmd.ord_wr_a)
        begin
            prev_reg <= ord_rdata_reg;
        end
    end

    tlac_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.pos_cap),
        .dividend (pos_rdata_reg),
        .divisor  (page_eff),
        .quotient (quotient),
        .done     (div_done)
    );

    assign cost_full = {1'b0, quotient} + 1'b1;

    always_comb
    begin
        cost_next = '0;
        if (kind_reg == KIND_ACCESS)
        begin
            // clamp the page number to the cost field
            if (32'(cost_full) > 32'(COST_MAX))
            begin
                cost_next = COST_W'(COST_MAX);
            end
            else
            begin
                cost_next = COST_W'(cost_full);
            end
        end
        // saturate the running total
        if (total_reg > TOTAL_MAX - TOTAL_W'(cost_next))
        begin
            total_next = TOTAL_MAX;
        end
        else
        begin
            total_next = total_reg + TOTAL_W'(cost_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            total_reg <= '0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.finish)
            begin
                total_reg <= total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            cost_reg <= cost_next;
        end
    end

    assign stat.pos_zero = (pos_rdata_reg == '0);
    assign stat.div_done = div_done;

    assign done        = done_reg;
    assign access_cost = cost_reg;
    assign total_cost  = total_reg;

endmodule

>>> design/tlac_ctrl.sv
// Controller: sequences table reads, the swap and the result transfer.
`timescale 1ns / 1ps

module tlac_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  kind,
    input  tlac_pkg::tlac_stat_t  stat,
    output tlac_pkg::tlac_cmd_t   cmd,
    output logic                  busy
);
    import tlac_pkg::*;

    tlac_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = (kind == KIND_ACCESS) ? ST_POS_RD : ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load_wr = 1'b1;
                cmd.finish  = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_POS_RD:
            begin
                state_next = ST_POS_CAP;
            end
            ST_POS_CAP:
            begin
                // launch the divider; skip the swap for the head of the list
                cmd.pos_cap = 1'b1;
                state_next  = stat.pos_zero ? ST_WAIT : ST_RD_HERE;
            end
            ST_RD_HERE:
            begin
                state_next = ST_RD_PREV;
            end
            ST_RD_PREV:
            begin
                cmd.ord_rd_prev = 1'b1;
                state_next      = ST_WR_A;
            end
            ST_WR_A:
            begin
                cmd.ord_wr_a = 1'b1;
                state_next   = ST_WR_B;
            end
            ST_WR_B:
            begin
                cmd.ord_wr_b = 1'b1;
                state_next   = ST_PP_WR;
            end
            ST_PP_WR:
            begin
                cmd.pp_wr  = 1'b1;
                state_next = ST_PI_RD;
            end
            ST_PI_RD:
            begin
                state_next = ST_PI_WR;
            end
            ST_PI_WR:
            begin
                cmd.pi_wr  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

>>> design/transpose_list_access_cost.sv
// Top level: transpose-rule list with paged access cost and APB page-size register.
// A load item's result is produced by the load state; an access item's result waits
// for the 10-step page divider, which runs beside the swap, to finish.
// Items are handled one at a time; start is taken whenever busy is low, including the
// cycle that shows the previous result.
// Reset clears the controller, the running total and sets the page size to 1;
// the tables hold nothing defined until loaded. Results cannot be stalled.
`timescale 1ns / 1ps

module transpose_list_access_cost
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          kind,
    input  logic [tlac_pkg::FIELD_W-1:0]  slot,
    input  logic [tlac_pkg::FIELD_W-1:0]  item_id,
    output logic                          done,
    output logic [tlac_pkg::COST_W-1:0]   access_cost,
    output logic [tlac_pkg::TOTAL_W-1:0]  total_cost,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tlac_pkg::ADDR_W-1:0]   paddr,
    input  logic [tlac_pkg::DATA_W-1:0]   pwdata,
    output logic [tlac_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import tlac_pkg::*;

    tlac_cmd_t         cmd;
    tlac_stat_t        stat;
    logic [PAGE_W-1:0] page_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg <= PAGE_W'(1);
        end
        else if (cfg_wr && paddr[2] == REG_ENTRIES_PER_PAGE)
        begin
            page_reg <= pwdata[PAGE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ENTRIES_PER_PAGE) ? DATA_W'(page_reg) : '0;

    tlac_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    tlac_dpath u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .kind        (kind),
        .slot        (slot),
        .item_id     (item_id),
        .page        (page_reg),
        .done        (done),
        .access_cost (access_cost),
        .total_cost  (total_cost)
    );

    // a result is only shown once the controller is back in idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // a load transfer yields its result once the load state is past
    a_load_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == KIND_LOAD) |-> ##2 done)
        else $error("load result not on time");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // the running total never decreases
    a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> total_cost >= $past(total_cost))
        else $error("running total went down");

endmodule

>>> tb/tlac_charge_checker.sv
// Checker for the transpose list cost block: tracks the list tables, predicts charges, compares.
`timescale 1ns / 1ps

module tlac_charge_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          kind,
    input  logic [tlac_pkg::FIELD_W-1:0]  slot,
    input  logic [tlac_pkg::FIELD_W-1:0]  item_id,
    input  logic                          done,
    input  logic [tlac_pkg::COST_W-1:0]   access_cost,
    input  logic [tlac_pkg::TOTAL_W-1:0]  total_cost,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [tlac_pkg::ADDR_W-1:0]   paddr,
    input  logic [tlac_pkg::DATA_W-1:0]   pwdata,
    output int                            fail_count,
    output int                            owed_count
);
    import tlac_pkg::*;

    localparam int unsigned COST_CAP = 2 ** COST_W - 1;

    typedef struct packed {
        logic [COST_W-1:0]  cost;
        logic [TOTAL_W-1:0] total;
    } charge_t;

    logic [IDX_W-1:0]   slot_to_id [ENTRIES];
    logic [IDX_W-1:0]   id_to_slot [ENTRIES];
    logic [TOTAL_W-1:0] total_sum;
    logic [PAGE_W-1:0]  page_size;
    charge_t            owed_charges [$];

    // Apply one item to the shadow tables and return the charge it produces.
    function automatic charge_t charge_item(input logic k, input logic [FIELD_W-1:0] s,
                                            input logic [FIELD_W-1:0] id);
        logic [IDX_W-1:0]  here_pos;
        logic [IDX_W-1:0]  prev_id;
        logic [IDX_W-1:0]  here_id;
        logic [PAGE_W-1:0] divisor;
        int unsigned       cost;
        charge_t           res;

        res.cost = '0;
        if (k == KIND_LOAD)
        begin
            slot_to_id[s]  = id;
            id_to_slot[id] = s;
        end
        else
        begin
            divisor  = (page_size == '0) ? PAGE_W'(1) : page_size;
            here_pos = id_to_slot[id];
            cost     = here_pos / divisor + 1;
            if (cost > COST_CAP)
                cost = COST_CAP;
            if (total_sum > TOTAL_MAX - TOTAL_W'(cost))
                total_sum = TOTAL_MAX;
            else
                total_sum = total_sum + TOTAL_W'(cost);
            if (here_pos != '0)
            begin
                // swap with predecessor; bump positions in this order, wrapping
                prev_id                  = slot_to_id[here_pos - 1'b1];
                here_id                  = slot_to_id[here_pos];
                slot_to_id[here_pos - 1'b1] = here_id;
                slot_to_id[here_pos]     = prev_id;
                id_to_slot[prev_id]      = id_to_slot[prev_id] + 1'b1;
                id_to_slot[id]           = id_to_slot[id] - 1'b1;
            end
            res.cost = COST_W'(cost);
        end
        res.total = total_sum;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        charge_t want;
        charge_t got;

        if (!rst_n)
        begin
            total_sum = '0;
            page_size = PAGE_W'(1);
            owed_charges.delete();
        end
        else
        begin
            if (done)
            begin
                if (owed_charges.size() == 0)
                begin
                    $error("unexpected result transfer: access_cost=%0d total_cost=%0d",
                           access_cost, total_cost);
                    fail_count++;
                end
                else
                begin
                    want = owed_charges.pop_front();
                    if (access_cost !== want.cost)
                    begin
                        $error("access_cost: expected %0d, got %0d", want.cost, access_cost);
                        fail_count++;
                    end
                    if (total_cost !== want.total)
                    begin
                        $error("total_cost: expected %0d, got %0d", want.total, total_cost);
                        fail_count++;
                    end
                end
            end

            if (psel && penable && pwrite && pready && paddr[2] == REG_ENTRIES_PER_PAGE)
                page_size = pwdata[PAGE_W-1:0];

            if (start && !busy)
            begin
                got          = charge_item(kind, slot, item_id);
                owed_charges = {owed_charges, got};
            end
        end
        owed_count = owed_charges.size();
    end

endmodule

>>> tb/transpose_list_access_cost_tb.sv
// Testbench top: clock, reset, item and register stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module transpose_list_access_cost_tb;

    import tlac_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 70;
    localparam int LIST_N      = 64;
    localparam logic [ADDR_W-1:0] PAGE_REG_ADDR   = {REG_ENTRIES_PER_PAGE, 2'b00};
    localparam logic [ADDR_W-1:0] UNUSED_REG_ADDR = {~REG_ENTRIES_PER_PAGE, 2'b00};

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                kind;
    logic [FIELD_W-1:0]  slot;
    logic [FIELD_W-1:0]  item_id;
    logic                done;
    logic [COST_W-1:0]   access_cost;
    logic [TOTAL_W-1:0]  total_cost;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int fail_count;
    int owed_count;
    int idle_pct;
    int quiet_cycles = 0;

    // head of the list as the block holds it; the random phases access only these ids
    logic [FIELD_W-1:0] list_ids [LIST_N];
    bit                 in_list [ENTRIES];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    transpose_list_access_cost i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .slot        (slot),
        .item_id     (item_id),
        .done        (done),
        .access_cost (access_cost),
        .total_cost  (total_cost),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    tlac_charge_checker i_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .slot        (slot),
        .item_id     (item_id),
        .done        (done),
        .access_cost (access_cost),
        .total_cost  (total_cost),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .fail_count  (fail_count),
        .owed_count  (owed_count)
    );

    // End the run if neither an item nor a result moves for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic k, input logic [FIELD_W-1:0] s,
                             input logic [FIELD_W-1:0] id);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start   <= 1'b1;
        kind    <= k;
        slot    <= s;
        item_id <= id;
        while (busy)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic send_access(input logic [FIELD_W-1:0] id);
        send_item(KIND_ACCESS, FIELD_W'($urandom_range(ENTRIES - 1)), id);
    endtask

    // Access the id at list position p and follow the transpose in the local list.
    task automatic access_at(input int p);
        logic [FIELD_W-1:0] moved_id;

        moved_id = list_ids[p];
        send_access(moved_id);
        if (p > 0)
        begin
            list_ids[p]     = list_ids[p - 1];
            list_ids[p - 1] = moved_id;
        end
    endtask

    // Drop start and wait until every owed result has come and the block is idle.
    task automatic settle_block();
        start <= 1'b0;
        while (owed_count != 0 || busy)
            @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [PAGE_W-1:0] value);
        logic [DATA_W-1:0] word;

        word              = $urandom;
        word[PAGE_W-1:0]  = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        int                 order_perm [ENTRIES];
        logic [PAGE_W-1:0]  page_plan [6];
        logic [FIELD_W-1:0] swap_id;
        logic [FIELD_W-1:0] fresh_id;
        int                 j;
        int                 tmp;
        int                 s1;
        int                 s2;
        int                 sent;
        int                 roll;
        int                 run_len;

        rst_n    = 1'b0;
        start    = 1'b0;
        kind     = KIND_LOAD;
        slot     = '0;
        item_id  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        idle_pct = 8;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Short list at the reset page size: no-swap front access, climb to the front.
        send_item(KIND_LOAD, 10'd0, 10'd1023);
        send_item(KIND_LOAD, 10'd1, 10'd0);
        send_item(KIND_LOAD, 10'd2, 10'd682);
        send_item(KIND_LOAD, 10'd3, 10'd341);
        send_item(KIND_ACCESS, 10'd1023, 10'd1023);
        repeat (4) send_item(KIND_ACCESS, 10'd1023, 10'd341);
        settle_block();
        // zero page size behaves as one
        write_reg(PAGE_REG_ADDR, '0);
        send_access(10'd682);
        settle_block();
        write_reg(PAGE_REG_ADDR, PAGE_W'(2));
        send_access(10'd0);
        send_access(10'd682);
        settle_block();
        // unmapped word: page size must stay at two
        write_reg(UNUSED_REG_ADDR, PAGE_W'(1));
        send_access(10'd0);
        settle_block();
        write_reg(PAGE_REG_ADDR, PAGE_W'(1));

        // Last list position: largest cost at page size one.
        send_item(KIND_LOAD, 10'd1022, 10'd900);
        send_item(KIND_LOAD, 10'd1023, 10'd77);
        send_access(10'd77);
        // Tables out of step: predecessor's recorded position wraps from the top to zero.
        send_item(KIND_LOAD, 10'd4, 10'd77);
        send_item(KIND_LOAD, 10'd1023, 10'd77);
        send_item(KIND_LOAD, 10'd5, 10'd900);
        send_access(10'd900);
        send_access(10'd77);

        // Load the head of the list with distinct shuffled ids; only listed ids are accessed.
        for (int i = 0; i < ENTRIES; i++)
            order_perm[i] = i;
        for (int i = ENTRIES - 1; i > 0; i--)
        begin
            j             = $urandom_range(i);
            tmp           = order_perm[i];
            order_perm[i] = order_perm[j];
            order_perm[j] = tmp;
        end
        for (int i = 0; i < LIST_N; i++)
        begin
            list_ids[i]                = FIELD_W'(order_perm[i]);
            in_list[list_ids[i]]       = 1'b1;
            send_item(KIND_LOAD, FIELD_W'(i), list_ids[i]);
        end

        page_plan[0] = PAGE_W'(1024);
        page_plan[1] = PAGE_W'(2047);
        page_plan[2] = PAGE_W'(1);
        page_plan[3] = PAGE_W'(5);
        page_plan[4] = '0;
        page_plan[5] = PAGE_W'($urandom_range(1, 1024));

        for (int ph = 0; ph < 6; ph++)
        begin
            idle_pct = (ph < 2) ? 8 : (ph < 4) ? 74 : 0;
            settle_block();
            write_reg(PAGE_REG_ADDR, page_plan[ph]);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                roll = $urandom_range(99);
                if (roll < 10)
                begin
                    // exchange two list positions with a pair of loads
                    s1           = $urandom_range(LIST_N - 1);
                    s2           = $urandom_range(LIST_N - 1);
                    swap_id      = list_ids[s1];
                    list_ids[s1] = list_ids[s2];
                    list_ids[s2] = swap_id;
                    send_item(KIND_LOAD, FIELD_W'(s1), list_ids[s1]);
                    send_item(KIND_LOAD, FIELD_W'(s2), list_ids[s2]);
                    sent = sent + 2;
                end
                else if (roll < 15)
                begin
                    // reload the head of the list with a fresh set of hot ids
                    run_len = $urandom_range(2, 16);
                    for (int i = 0; i < run_len; i++)
                    begin
                        fresh_id = FIELD_W'($urandom_range(ENTRIES - 1));
                        while (in_list[fresh_id])
                            fresh_id = FIELD_W'($urandom_range(ENTRIES - 1));
                        in_list[list_ids[i]] = 1'b0;
                        in_list[fresh_id]    = 1'b1;
                        list_ids[i]          = fresh_id;
                        send_item(KIND_LOAD, FIELD_W'(i), fresh_id);
                    end
                    sent = sent + run_len;
                end
                else if (roll < 70)
                begin
                    access_at($urandom_range(7));
                    sent++;
                end
                else
                begin
                    access_at($urandom_range(LIST_N - 1));
                    sent++;
                end
            end
        end

        settle_block();
        if (fail_count == 0 && owed_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> transpose_list_access_cost.f
design/tlac_pkg.sv
design/tlac_div.sv
design/tlac_dpath.sv
design/tlac_ctrl.sv
design/transpose_list_access_cost.sv
tb/tlac_charge_checker.sv
tb/transpose_list_access_cost_tb.sv
